// ----- hdl/sfr_pkg.sv -----
// ----------------------------------------------------------------------------
// sfr_pkg
// shared types, constants and width helpers of the serial frame receiver
// ----------------------------------------------------------------------------
package sfr_pkg;

    // default largest payload a frame may carry
    localparam int SFR_MAX_PAYLOAD = 32;

    // frames that may wait between parser and emitter (power of two)
    localparam int SFR_QDEPTH = 2;

    // configuration register map
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_OWN_ADDR  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DUP_START = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_END       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ESCAPE    = 3'd4;

    // reset values of the flag bytes
    localparam logic [7:0] RST_START_FLAG = 8'hFF;
    localparam logic [7:0] RST_DUP_FLAG   = 8'hFC;
    localparam logic [7:0] RST_END_FLAG   = 8'hFE;
    localparam logic [7:0] RST_ESC_FLAG   = 8'hFD;

    localparam logic [7:0] BROADCAST_ADDR = 8'hFF;

    // parser phases
    typedef enum logic [7:0] {
        PH_START  = 8'b0000_0001,
        PH_LENGTH = 8'b0000_0010,
        PH_SENDER = 8'b0000_0100,
        PH_TARGET = 8'b0000_1000,
        PH_ID     = 8'b0001_0000,
        PH_DATA   = 8'b0010_0000,
        PH_CHECK  = 8'b0100_0000,
        PH_END    = 8'b1000_0000
    } sfr_phase_t;

    // per frame header handed from parser to emitter
    typedef struct packed {
        logic [7:0]  sender;
        logic [7:0]  sent_id;
        logic [15:0] msg_number;
    } sfr_desc_t;

    // width of a count that reaches n
    function automatic int cnt_w(input int n);
        return $clog2(n + 1);
    endfunction

    // width of an index below n
    function automatic int idx_w(input int n);
        return (n > 1) ? $clog2(n) : 1;
    endfunction

endpackage

// ----- hdl/sfr_front.sv -----
// ----------------------------------------------------------------------------
// sfr_front
// frame parser: flag and escape handling, header capture, checksum, address
// and duplicate filtering; writes payload words into the frame buffer
// ----------------------------------------------------------------------------
module sfr_front #(
    parameter int MAX_PAYLOAD = sfr_pkg::SFR_MAX_PAYLOAD
) (
    input  logic                                       aclk,
    input  logic                                       aresetn,
    input  logic                                       cfg_valid,
    input  logic [sfr_pkg::CFG_IDX_W-1:0]              cfg_index,
    input  logic [7:0]                                 cfg_data,
    input  logic                                       s_valid,
    input  logic [7:0]                                 s_rx_byte,
    input  logic                                       q_full,
    output logic                                       pl_wr_en,
    output logic [sfr_pkg::idx_w(MAX_PAYLOAD)-1:0]     pl_wr_idx,
    output logic [7:0]                                 pl_wr_data,
    output logic                                       push,
    output sfr_pkg::sfr_desc_t                         push_desc,
    output logic [sfr_pkg::cnt_w(MAX_PAYLOAD)-1:0]     push_len
);
    import sfr_pkg::*;

    localparam int CNT_W = cnt_w(MAX_PAYLOAD);
    localparam int IDX_W = idx_w(MAX_PAYLOAD);

    logic [7:0] own_addr_reg, start_flag_reg, dup_flag_reg, end_flag_reg, esc_flag_reg;

    sfr_phase_t       phase_reg, phase_next;
    logic             dup_reg, dup_next;
    logic             esc_reg, esc_next;
    logic [CNT_W-1:0] len_reg, len_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [7:0]       sum_reg, sum_next;
    logic [7:0]       sender_reg, sender_next;
    logic [7:0]       target_reg, target_next;
    logic [7:0]       id_reg, id_next;
    logic [15:0]      acc_cnt_reg, acc_cnt_next;

    // last accepted id per sender
    logic [7:0]   lid_mem [256];
    logic [255:0] lid_valid_reg;
    logic [7:0]   lid_rd_data_reg;
    logic         lid_rd_valid_reg;
    logic         lid_wr;

    logic take, is_start, is_dup, is_end, is_esc, literal, target_ok, is_repeat;
    logic rst_frame, rst_dup;
    sfr_phase_t rst_phase;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            own_addr_reg   <= 8'h00;
            start_flag_reg <= RST_START_FLAG;
            dup_flag_reg   <= RST_DUP_FLAG;
            end_flag_reg   <= RST_END_FLAG;
            esc_flag_reg   <= RST_ESC_FLAG;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_OWN_ADDR:  own_addr_reg   <= (cfg_data == BROADCAST_ADDR) ? 8'h00 : cfg_data;
                CFG_START:     start_flag_reg <= cfg_data;
                CFG_DUP_START: dup_flag_reg   <= cfg_data;
                CFG_END:       end_flag_reg   <= cfg_data;
                CFG_ESCAPE:    esc_flag_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    assign take      = s_valid && !q_full;
    assign is_start  = (s_rx_byte == start_flag_reg);
    assign is_dup    = (s_rx_byte == dup_flag_reg);
    assign is_end    = (s_rx_byte == end_flag_reg);
    assign is_esc    = (s_rx_byte == esc_flag_reg);
    assign literal   = esc_reg || !(is_start || is_dup || is_end || is_esc);
    assign target_ok = (target_reg == own_addr_reg) || (target_reg == BROADCAST_ADDR);
    assign is_repeat = dup_reg && lid_rd_valid_reg && (lid_rd_data_reg == id_reg);

    always_comb begin
        phase_next   = phase_reg;
        dup_next     = dup_reg;
        esc_next     = esc_reg;
        len_next     = len_reg;
        count_next   = count_reg;
        sum_next     = sum_reg;
        sender_next  = sender_reg;
        target_next  = target_reg;
        id_next      = id_reg;
        acc_cnt_next = acc_cnt_reg;
        push         = 1'b0;
        pl_wr_en     = 1'b0;
        lid_wr       = 1'b0;
        rst_frame    = 1'b0;
        rst_phase    = PH_START;
        rst_dup      = 1'b0;

        if (take) begin
            if (phase_reg == PH_START) begin
                // hunting: escape is not honoured here
                if (is_start) begin
                    rst_frame = 1'b1;
                    rst_phase = PH_LENGTH;
                end else if (is_dup) begin
                    rst_frame = 1'b1;
                    rst_phase = PH_LENGTH;
                    rst_dup   = 1'b1;
                end
            end else if (phase_reg == PH_END) begin
                if (is_end && target_ok && !is_repeat) begin
                    push         = 1'b1;
                    lid_wr       = 1'b1;
                    acc_cnt_next = acc_cnt_reg + 16'd1;
                end
                rst_frame = 1'b1;
            end else if (!literal) begin
                // unescaped flag inside a frame
                if (is_start) begin
                    rst_frame = 1'b1;
                    rst_phase = PH_LENGTH;
                end else if (is_dup) begin
                    rst_frame = 1'b1;
                    rst_phase = PH_LENGTH;
                    rst_dup   = 1'b1;
                end else if (is_end) begin
                    rst_frame = 1'b1;
                end else begin
                    esc_next = 1'b1;
                end
            end else begin
                esc_next = 1'b0;
                case (phase_reg)
                    PH_LENGTH: begin
                        if (s_rx_byte > 8'(MAX_PAYLOAD)) begin
                            rst_frame = 1'b1;
                        end else begin
                            len_next   = CNT_W'(s_rx_byte);
                            sum_next   = s_rx_byte;
                            phase_next = PH_SENDER;
                        end
                    end
                    PH_SENDER: begin
                        sender_next = s_rx_byte;
                        sum_next    = sum_reg + s_rx_byte;
                        phase_next  = PH_TARGET;
                    end
                    PH_TARGET: begin
                        target_next = s_rx_byte;
                        sum_next    = sum_reg + s_rx_byte;
                        phase_next  = PH_ID;
                    end
                    PH_ID: begin
                        id_next    = s_rx_byte;
                        sum_next   = sum_reg + s_rx_byte;
                        phase_next = (len_reg == '0) ? PH_CHECK : PH_DATA;
                    end
                    PH_DATA: begin
                        pl_wr_en   = 1'b1;
                        count_next = count_reg + CNT_W'(1);
                        sum_next   = sum_reg + s_rx_byte;
                        if (count_next >= len_reg) begin
                            phase_next = PH_CHECK;
                        end
                    end
                    PH_CHECK: begin
                        if (s_rx_byte != sum_reg) begin
                            rst_frame = 1'b1;
                        end else begin
                            phase_next = PH_END;
                        end
                    end
                    default: ;
                endcase
            end
        end

        if (rst_frame) begin
            phase_next = rst_phase;
            dup_next   = rst_dup;
            esc_next   = 1'b0;
            count_next = '0;
            sum_next   = 8'h00;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_START;
            dup_reg       <= 1'b0;
            esc_reg       <= 1'b0;
            count_reg     <= '0;
            sum_reg       <= 8'h00;
            acc_cnt_reg   <= 16'd0;
            lid_valid_reg <= '0;
        end else begin
            phase_reg   <= phase_next;
            dup_reg     <= dup_next;
            esc_reg     <= esc_next;
            count_reg   <= count_next;
            sum_reg     <= sum_next;
            acc_cnt_reg <= acc_cnt_next;
            if (lid_wr) begin
                lid_valid_reg[sender_reg] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        len_reg          <= len_next;
        sender_reg       <= sender_next;
        target_reg       <= target_next;
        id_reg           <= id_next;
        lid_rd_valid_reg <= lid_valid_reg[sender_reg];
    end

    // id table: one write port, one registered read port at the current sender
    always_ff @(posedge aclk) begin
        if (lid_wr) begin
            lid_mem[sender_reg] <= id_reg;
        end
        lid_rd_data_reg <= lid_mem[sender_reg];
    end

    assign pl_wr_idx            = IDX_W'(count_reg);
    assign pl_wr_data           = s_rx_byte;
    assign push_desc.sender     = sender_reg;
    assign push_desc.sent_id    = id_reg;
    assign push_desc.msg_number = acc_cnt_reg;
    assign push_len             = len_reg;

endmodule

// ----- hdl/sfr_frame_buf.sv -----
// ----------------------------------------------------------------------------
// sfr_frame_buf
// queue of accepted frame headers with one payload bank per queue slot
// ----------------------------------------------------------------------------
module sfr_frame_buf #(
    parameter int MAX_PAYLOAD = sfr_pkg::SFR_MAX_PAYLOAD
) (
    input  logic                                       aclk,
    input  logic                                       aresetn,
    input  logic                                       push,
    input  sfr_pkg::sfr_desc_t                         push_desc,
    input  logic [sfr_pkg::cnt_w(MAX_PAYLOAD)-1:0]     push_len,
    output logic                                       full,
    input  logic                                       pl_wr_en,
    input  logic [sfr_pkg::idx_w(MAX_PAYLOAD)-1:0]     pl_wr_idx,
    input  logic [7:0]                                 pl_wr_data,
    output logic                                       head_valid,
    output sfr_pkg::sfr_desc_t                         head_desc,
    output logic [sfr_pkg::cnt_w(MAX_PAYLOAD)-1:0]     head_len,
    input  logic                                       pop,
    input  logic                                       rd_en,
    input  logic [sfr_pkg::idx_w(MAX_PAYLOAD)-1:0]     rd_idx,
    output logic [7:0]                                 rd_data
);
    import sfr_pkg::*;

    localparam int CNT_W  = cnt_w(MAX_PAYLOAD);
    localparam int IDX_W  = idx_w(MAX_PAYLOAD);
    localparam int QPTR_W = idx_w(SFR_QDEPTH);
    localparam int QCNT_W = cnt_w(SFR_QDEPTH);
    localparam int PL_DEPTH = SFR_QDEPTH * (2 ** IDX_W);

    sfr_desc_t        desc_q [SFR_QDEPTH];
    logic [CNT_W-1:0] len_q  [SFR_QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg, count_next;

    logic [7:0] pl_mem [PL_DEPTH];
    logic [7:0] rd_data_reg;

    always_comb begin
        case ({push, pop})
            2'b10:   count_next = count_reg + QCNT_W'(1);
            2'b01:   count_next = count_reg - QCNT_W'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            desc_q[wr_ptr_reg] <= push_desc;
            len_q[wr_ptr_reg]  <= push_len;
        end
    end

    // payload banks: the parser fills the bank of the slot it will push next
    always_ff @(posedge aclk) begin
        if (pl_wr_en) begin
            pl_mem[{wr_ptr_reg, pl_wr_idx}] <= pl_wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= pl_mem[{rd_ptr_reg, rd_idx}];
        end
    end

    assign full       = (count_reg == QCNT_W'(SFR_QDEPTH));
    assign head_valid = (count_reg != '0);
    assign head_desc  = desc_q[rd_ptr_reg];
    assign head_len   = len_q[rd_ptr_reg];
    assign rd_data    = rd_data_reg;

endmodule

// ----- hdl/sfr_back.sv -----
// ----------------------------------------------------------------------------
// sfr_back
// emitter: walks the payload of the head frame and drives the result words
// ----------------------------------------------------------------------------
module sfr_back #(
    parameter int MAX_PAYLOAD = sfr_pkg::SFR_MAX_PAYLOAD
) (
    input  logic                                       aclk,
    input  logic                                       aresetn,
    input  logic                                       head_valid,
    input  sfr_pkg::sfr_desc_t                         head_desc,
    input  logic [sfr_pkg::cnt_w(MAX_PAYLOAD)-1:0]     head_len,
    output logic                                       pop,
    output logic                                       rd_en,
    output logic [sfr_pkg::idx_w(MAX_PAYLOAD)-1:0]     rd_idx,
    input  logic [7:0]                                 rd_data,
    output logic                                       m_valid,
    input  logic                                       m_ready,
    output logic [7:0]                                 m_sender,
    output logic [7:0]                                 m_sent_id,
    output logic [15:0]                                m_msg_number,
    output logic [5:0]                                 m_payload_length,
    output logic [7:0]                                 m_data_byte,
    output logic                                       m_byte_valid,
    output logic                                       m_last
);
    import sfr_pkg::*;

    localparam int CNT_W = cnt_w(MAX_PAYLOAD);
    localparam int IDX_W = idx_w(MAX_PAYLOAD);

    logic [IDX_W-1:0] idx_reg;
    logic             rd_pend_reg;
    sfr_desc_t        pend_desc_reg;
    logic [CNT_W-1:0] pend_len_reg;
    logic             pend_bvalid_reg, pend_last_reg;

    logic             m_valid_reg;
    sfr_desc_t        m_desc_reg;
    logic [5:0]       m_len_reg;
    logic [7:0]       m_data_reg;
    logic             m_bvalid_reg, m_last_reg;

    logic load_out, issue, item_last, empty_frame;

    assign empty_frame = (head_len == '0);
    assign item_last   = empty_frame || (CNT_W'(CNT_W'(idx_reg) + CNT_W'(1)) == head_len);
    assign load_out    = rd_pend_reg && (!m_valid_reg || m_ready);
    assign issue       = head_valid && (!rd_pend_reg || load_out);
    assign pop         = issue && item_last;
    assign rd_en       = issue;
    assign rd_idx      = idx_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg     <= '0;
            rd_pend_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (issue) begin
                idx_reg <= item_last ? '0 : IDX_W'(idx_reg + IDX_W'(1));
            end
            if (issue) begin
                rd_pend_reg <= 1'b1;
            end else if (load_out) begin
                rd_pend_reg <= 1'b0;
            end
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (issue) begin
            pend_desc_reg   <= head_desc;
            pend_len_reg    <= head_len;
            pend_bvalid_reg <= !empty_frame;
            pend_last_reg   <= item_last;
        end
        if (load_out) begin
            m_desc_reg   <= pend_desc_reg;
            m_len_reg    <= 6'(pend_len_reg);
            m_data_reg   <= pend_bvalid_reg ? rd_data : 8'h00;
            m_bvalid_reg <= pend_bvalid_reg;
            m_last_reg   <= pend_last_reg;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_sender         = m_desc_reg.sender;
    assign m_sent_id        = m_desc_reg.sent_id;
    assign m_msg_number     = m_desc_reg.msg_number;
    assign m_payload_length = m_len_reg;
    assign m_data_byte      = m_data_reg;
    assign m_byte_valid     = m_bvalid_reg;
    assign m_last           = m_last_reg;

endmodule

// ----- hdl/serial_frame_receiver_top.sv -----
// Receives a byte-stuffed serial stream one word at a time on the s_ channel
// and delivers every accepted frame on the m_ channel as a burst of payload
// words (one word with byte_valid low for an empty frame), all carrying
// sender, id, message number and length, with last on the final word. The
// parser takes one byte per cycle as long as the two-slot frame queue has
// room; s_ready drops only while two complete frames are waiting to be sent.
// The emitter drives one result word per cycle from the payload buffer while
// m_ready is high, through the queue write, buffer read and output register.
// Flag values and own address are set through the cfg_ write channel, which is
// always ready; write it only while no frame is in flight. The per-sender
// duplicate table needs no clearing pass after reset.
// ----------------------------------------------------------------------------
// serial_frame_receiver_top
// byte-stuffed frame receiver with checksum, address and duplicate filtering
// ----------------------------------------------------------------------------
module serial_frame_receiver_top #(
    parameter int MAX_PAYLOAD = sfr_pkg::SFR_MAX_PAYLOAD
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // configuration writes
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [sfr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [7:0]                     cfg_data,
    // received bytes
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [7:0]                     s_rx_byte,
    // result words
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [7:0]                     m_sender,
    output logic [7:0]                     m_sent_id,
    output logic [15:0]                    m_msg_number,
    output logic [5:0]                     m_payload_length,
    output logic [7:0]                     m_data_byte,
    output logic                           m_byte_valid,
    output logic                           m_last
);
    import sfr_pkg::*;

    localparam int CNT_W = cnt_w(MAX_PAYLOAD);
    localparam int IDX_W = idx_w(MAX_PAYLOAD);

    // parser to frame buffer
    logic             q_full;
    logic             push;
    sfr_desc_t        push_desc;
    logic [CNT_W-1:0] push_len;
    logic             pl_wr_en;
    logic [IDX_W-1:0] pl_wr_idx;
    logic [7:0]       pl_wr_data;

    // frame buffer to emitter
    logic             head_valid;
    sfr_desc_t        head_desc;
    logic [CNT_W-1:0] head_len;
    logic             pop;
    logic             rd_en;
    logic [IDX_W-1:0] rd_idx;
    logic [7:0]       rd_data;

    // registers take a write every cycle
    assign cfg_ready = 1'b1;
    // parser stalls only while every payload bank holds a waiting frame
    assign s_ready   = !q_full;

    sfr_front #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_valid  (cfg_valid),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .s_valid    (s_valid),
        .s_rx_byte  (s_rx_byte),
        .q_full     (q_full),
        .pl_wr_en   (pl_wr_en),
        .pl_wr_idx  (pl_wr_idx),
        .pl_wr_data (pl_wr_data),
        .push       (push),
        .push_desc  (push_desc),
        .push_len   (push_len)
    );

    sfr_frame_buf #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_frame_buf (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_desc  (push_desc),
        .push_len   (push_len),
        .full       (q_full),
        .pl_wr_en   (pl_wr_en),
        .pl_wr_idx  (pl_wr_idx),
        .pl_wr_data (pl_wr_data),
        .head_valid (head_valid),
        .head_desc  (head_desc),
        .head_len   (head_len),
        .pop        (pop),
        .rd_en      (rd_en),
        .rd_idx     (rd_idx),
        .rd_data    (rd_data)
    );

    sfr_back #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .head_valid       (head_valid),
        .head_desc        (head_desc),
        .head_len         (head_len),
        .pop              (pop),
        .rd_en            (rd_en),
        .rd_idx           (rd_idx),
        .rd_data          (rd_data),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_sender         (m_sender),
        .m_sent_id        (m_sent_id),
        .m_msg_number     (m_msg_number),
        .m_payload_length (m_payload_length),
        .m_data_byte      (m_data_byte),
        .m_byte_valid     (m_byte_valid),
        .m_last           (m_last)
    );

    // a frame is never pushed into a full queue
    assert property (@(posedge aclk) disable iff (!aresetn) q_full |-> !push)
        else $error("frame pushed into full queue");

    // the emitter only retires a frame that is present
    assert property (@(posedge aclk) disable iff (!aresetn) pop |-> head_valid)
        else $error("pop from empty frame queue");

    // payload reads only target a queued frame
    assert property (@(posedge aclk) disable iff (!aresetn) rd_en |-> head_valid)
        else $error("payload read without a queued frame");

    // an empty-frame word is always the final word of its frame
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_byte_valid) |-> m_last)
        else $error("empty-frame word without last");

endmodule

// ----- tb/serial_frame_receiver_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// serial_frame_receiver_checker
// watches the config, byte and result channels of the frame receiver, keeps
// its own copy of the parser and duplicate table, and compares every result
// word with the oldest predicted one
// ----------------------------------------------------------------------------
module serial_frame_receiver_checker #(
    parameter int MAX_PAYLOAD = sfr_pkg::SFR_MAX_PAYLOAD
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    input  logic                          cfg_ready,
    input  logic [sfr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]                    cfg_data,
    input  logic                          s_valid,
    input  logic                          s_ready,
    input  logic [7:0]                    s_rx_byte,
    input  logic                          m_valid,
    input  logic                          m_ready,
    input  logic [7:0]                    m_sender,
    input  logic [7:0]                    m_sent_id,
    input  logic [15:0]                   m_msg_number,
    input  logic [5:0]                    m_payload_length,
    input  logic [7:0]                    m_data_byte,
    input  logic                          m_byte_valid,
    input  logic                          m_last,
    output int                            fail_count,
    output int                            words_pending,
    output int                            words_predicted
);
    import sfr_pkg::*;

    typedef struct packed {
        logic [7:0]  sender;
        logic [7:0]  sent_id;
        logic [15:0] msg_number;
        logic [5:0]  payload_length;
        logic [7:0]  data_byte;
        logic        byte_valid;
        logic        last;
    } frame_word_t;

    frame_word_t expected_words[$];
    int          mismatches = 0;
    int          predicted_total = 0;

    // register copies
    logic [7:0]  own_addr, start_byte, dup_byte, end_byte, esc_byte;

    // parser copy
    sfr_phase_t  phase;
    logic        dup_copy, esc_armed;
    logic [7:0]  hdr_len, hdr_sender, hdr_target, hdr_id;
    logic [7:0]  data_count, sum;
    logic [7:0]  data_store [MAX_PAYLOAD];
    logic [8:0]  last_id [256];
    logic [15:0] accept_count;

    function automatic string describe(input frame_word_t w);
        return $sformatf("snd %02h id %02h num %0d len %0d data %02h bv %0b last %0b",
                         w.sender, w.sent_id, w.msg_number, w.payload_length,
                         w.data_byte, w.byte_valid, w.last);
    endfunction

    task automatic report(input string msg);
        mismatches++;
        if (mismatches <= 10) $display("%s", msg);
    endtask

    task automatic clear_frame();
        phase = PH_START;
        dup_copy = 1'b0;
        esc_armed = 1'b0;
        data_count = '0;
        sum = '0;
    endtask

    task automatic reset_model();
        own_addr = '0;
        start_byte = RST_START_FLAG;
        dup_byte = RST_DUP_FLAG;
        end_byte = RST_END_FLAG;
        esc_byte = RST_ESC_FLAG;
        clear_frame();
        hdr_len = '0;
        hdr_sender = '0;
        hdr_target = '0;
        hdr_id = '0;
        accept_count = '0;
        foreach (data_store[i]) data_store[i] = '0;
        foreach (last_id[i]) last_id[i] = '0;
        expected_words.delete();
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] d);
        case (idx)
            CFG_OWN_ADDR:  own_addr = (d == BROADCAST_ADDR) ? 8'h00 : d;
            CFG_START:     start_byte = d;
            CFG_DUP_START: dup_byte = d;
            CFG_END:       end_byte = d;
            CFG_ESCAPE:    esc_byte = d;
            default: ;
        endcase
    endtask

    // flag handling inside a frame; used is set when the byte was a control
    task automatic take_flag(input logic [7:0] b, output bit used);
        used = 1'b1;
        if (esc_armed) begin
            esc_armed = 1'b0;
            used = 1'b0;
        end else if (b == start_byte) begin
            clear_frame();
            phase = PH_LENGTH;
        end else if (b == dup_byte) begin
            clear_frame();
            phase = PH_LENGTH;
            dup_copy = 1'b1;
        end else if (b == end_byte) begin
            clear_frame();
        end else if (b == esc_byte) begin
            esc_armed = 1'b1;
        end else begin
            used = 1'b0;
        end
    endtask

    task automatic queue_frame();
        frame_word_t w;
        w.sender = hdr_sender;
        w.sent_id = hdr_id;
        w.msg_number = accept_count;
        accept_count++;
        last_id[hdr_sender] = {1'b1, hdr_id};
        if (hdr_len == 0) begin
            w.payload_length = '0;
            w.data_byte = '0;
            w.byte_valid = 1'b0;
            w.last = 1'b1;
            expected_words = {expected_words, w};
            predicted_total++;
        end else begin
            for (int k = 0; k < hdr_len && k < MAX_PAYLOAD; k++) begin
                w.payload_length = hdr_len[5:0];
                w.data_byte = data_store[k];
                w.byte_valid = 1'b1;
                w.last = (k + 1 == hdr_len);
                expected_words = {expected_words, w};
                predicted_total++;
            end
        end
    endtask

    task automatic predict_byte(input logic [7:0] b);
        bit used;
        case (phase)
            PH_START: begin
                if (b == start_byte) begin
                    clear_frame();
                    phase = PH_LENGTH;
                end else if (b == dup_byte) begin
                    clear_frame();
                    phase = PH_LENGTH;
                    dup_copy = 1'b1;
                end
            end
            PH_LENGTH: begin
                take_flag(b, used);
                if (!used) begin
                    if (b > MAX_PAYLOAD) begin
                        clear_frame();
                    end else begin
                        hdr_len = b;
                        sum = b;
                        phase = PH_SENDER;
                    end
                end
            end
            PH_SENDER: begin
                take_flag(b, used);
                if (!used) begin
                    hdr_sender = b;
                    sum += b;
                    phase = PH_TARGET;
                end
            end
            PH_TARGET: begin
                take_flag(b, used);
                if (!used) begin
                    hdr_target = b;
                    sum += b;
                    phase = PH_ID;
                end
            end
            PH_ID: begin
                take_flag(b, used);
                if (!used) begin
                    hdr_id = b;
                    sum += b;
                    phase = (hdr_len == 0) ? PH_CHECK : PH_DATA;
                end
            end
            PH_DATA: begin
                take_flag(b, used);
                if (!used) begin
                    if (data_count < MAX_PAYLOAD) data_store[data_count] = b;
                    data_count++;
                    sum += b;
                    if (data_count >= hdr_len) phase = PH_CHECK;
                end
            end
            PH_CHECK: begin
                take_flag(b, used);
                if (!used) begin
                    if (b != sum) clear_frame();
                    else phase = PH_END;
                end
            end
            PH_END: begin
                if (b == end_byte &&
                    (hdr_target == own_addr || hdr_target == BROADCAST_ADDR) &&
                    !(dup_copy && last_id[hdr_sender][8] &&
                      last_id[hdr_sender][7:0] == hdr_id))
                    queue_frame();
                clear_frame();
            end
            default: clear_frame();
        endcase
    endtask

    always @(posedge aclk) begin
        frame_word_t got, want;
        if (!aresetn) begin
            reset_model();
        end else begin
            if (m_valid && m_ready) begin
                got.sender = m_sender;
                got.sent_id = m_sent_id;
                got.msg_number = m_msg_number;
                got.payload_length = m_payload_length;
                got.data_byte = m_data_byte;
                got.byte_valid = m_byte_valid;
                got.last = m_last;
                if (expected_words.size() == 0) begin
                    report($sformatf("unexpected word: got %s", describe(got)));
                end else begin
                    want = expected_words[0];
                    expected_words.delete(0);
                    if (got !== want)
                        report($sformatf("word mismatch: expected %s, got %s",
                                         describe(want), describe(got)));
                end
            end
            if (cfg_valid && cfg_ready) write_reg(cfg_index, cfg_data);
            if (s_valid && s_ready) predict_byte(s_rx_byte);
        end
        fail_count <= mismatches;
        words_pending <= expected_words.size();
        words_predicted <= predicted_total;
    end

endmodule

// ----- tb/serial_frame_receiver_top_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// serial_frame_receiver_top_test
// drives stuffed byte streams and register settings into the frame receiver;
// directed frames first (empty, full, escaped, broken, duplicate, foreign and
// equal-flag cases), then random frames under a random flag setting, with
// bursty input and a stalling receiver; a checker alongside does the scoring
// ----------------------------------------------------------------------------
module serial_frame_receiver_top_test;
    import sfr_pkg::*;

    localparam int MAX_PAYLOAD = SFR_MAX_PAYLOAD;
    // the end flag passes queue, buffer read and output registers; leave a margin
    localparam int SETTLE_CYCLES = 8;
    // first index past the register map, must be ignored by the block
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 3'd5;

    // ways a frame can be spoilt on the link
    typedef enum {
        FLAW_NONE,
        FLAW_SUM,
        FLAW_NO_END,
        FLAW_CUT,
        FLAW_OVERSIZE
    } frame_flaw_t;

    // receiver behaviour on the result channel
    typedef enum {
        RX_OPEN,
        RX_COIN,
        RX_MASK,
        RX_SPARSE
    } rx_mode_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [7:0]           cfg_data = '0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic [7:0]           s_rx_byte = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic [7:0]           m_sender;
    logic [7:0]           m_sent_id;
    logic [15:0]          m_msg_number;
    logic [5:0]           m_payload_length;
    logic [7:0]           m_data_byte;
    logic                 m_byte_valid;
    logic                 m_last;

    int fail_count, words_pending, words_predicted;

    // what the stimulus side knows of the current settings
    logic [7:0] own_addr_now = 8'h00;
    logic [7:0] start_now = RST_START_FLAG;
    logic [7:0] dup_now = RST_DUP_FLAG;
    logic [7:0] end_now = RST_END_FLAG;
    logic [7:0] esc_now = RST_ESC_FLAG;
    // byte stuffing only works while all four flags differ
    bit         stuffing_ok = 1'b1;

    // sender burst state
    bit         src_active = 1'b0;
    int         burst_left = 0;
    int         link_bytes = 0;

    // last frame sent, reused for duplicate copies
    logic [7:0] prev_snd = 8'h00;
    logic [7:0] prev_id = 8'h00;

    // receiver stall state
    rx_mode_t   rx_mode = RX_OPEN;
    int         rx_hold = 0;
    logic [15:0] rx_mask = 16'hFFFF;
    logic [3:0] rx_tick = '0;

    serial_frame_receiver_top u_top (.*);

    serial_frame_receiver_checker u_checker (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // receiver: stretches of open flow, coin tosses, a rotating mask and
    // sparse ready, each for a random number of cycles
    always @(posedge aclk) begin
        if (rx_hold == 0) begin
            rx_mode = rx_mode_t'($urandom_range(0, 3));
            rx_hold = $urandom_range(20, 80);
            rx_mask = 16'($urandom) | 16'h0001;
        end else begin
            rx_hold--;
        end
        rx_tick++;
        case (rx_mode)
            RX_OPEN:   m_ready <= 1'b1;
            RX_COIN:   m_ready <= 1'($urandom_range(0, 1));
            RX_MASK:   m_ready <= rx_mask[rx_tick];
            RX_SPARSE: m_ready <= ($urandom_range(0, 3) == 0);
            default:   m_ready <= 1'b1;
        endcase
    end

    // hard stop in case the block hangs
    initial begin
        #2_000_000;
        $display("TB_ERROR");
        $finish;
    end

    function automatic bit is_flag(input logic [7:0] b);
        return b == start_now || b == dup_now || b == end_now || b == esc_now;
    endfunction

    // payload byte; flag values are favoured while they can be escaped
    function automatic logic [7:0] any_byte();
        logic [7:0] v;
        if (!stuffing_ok) begin
            do v = 8'($urandom); while (is_flag(v));
        end else if ($urandom_range(0, 3) == 0) begin
            case ($urandom_range(0, 3))
                0:       v = start_now;
                1:       v = dup_now;
                2:       v = end_now;
                default: v = esc_now;
            endcase
        end else begin
            v = 8'($urandom);
        end
        return v;
    endfunction

    // one word on the byte channel; valid stays up across a burst and
    // drops only when the burst runs out
    task automatic send_byte(input logic [7:0] b);
        if (!src_active) begin
            repeat ($urandom_range(1, 6)) @(posedge aclk);
            burst_left = ($urandom_range(0, 7) == 0) ? 64 : $urandom_range(1, 12);
        end
        s_rx_byte <= b;
        s_valid <= 1'b1;
        src_active = 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        link_bytes++;
        burst_left--;
        if (burst_left == 0) begin
            s_valid <= 1'b0;
            src_active = 1'b0;
        end
    endtask

    task automatic stop_source();
        if (src_active) begin
            s_valid <= 1'b0;
            src_active = 1'b0;
        end
    endtask

    // frame field with stuffing; an ordinary byte is escaped now and then too
    task automatic send_field(input logic [7:0] b);
        if (stuffing_ok && (is_flag(b) || $urandom_range(0, 9) == 0)) send_byte(esc_now);
        send_byte(b);
    endtask

    task automatic send_frame(input bit dup, input int len, input logic [7:0] snd,
                              input logic [7:0] tgt, input logic [7:0] id,
                              input frame_flaw_t flaw);
        logic [7:0] payload[$];
        logic [7:0] body[$];
        logic [7:0] sum;
        int         cut;
        send_byte(dup ? dup_now : start_now);
        send_field(8'(len));
        // an oversized length drops the frame on the spot
        if (flaw == FLAW_OVERSIZE) return;
        sum = 8'(len) + snd + tgt + id;
        for (int k = 0; k < len; k++) begin
            payload = {payload, any_byte()};
            sum += payload[k];
        end
        // without stuffing the id is nudged until neither it nor the sum is a flag
        while (!stuffing_ok && (is_flag(id) || is_flag(sum))) begin
            id++;
            sum++;
        end
        if (flaw == FLAW_SUM) sum ^= 8'(1 << $urandom_range(0, 7));
        body = {body, snd, tgt, id};
        foreach (payload[k]) body = {body, payload[k]};
        body = {body, sum};
        cut = (flaw == FLAW_CUT) ? $urandom_range(0, body.size() - 1) : body.size();
        for (int i = 0; i < cut; i++) send_field(body[i]);
        if (flaw == FLAW_CUT) begin
            // abandon mid-frame: silence (next start restarts), end or dup-start
            case ($urandom_range(0, 2))
                1: send_byte(end_now);
                2: send_byte(dup_now);
                default: ;
            endcase
            return;
        end
        // a missing end swallows the byte in its place, even a start flag
        send_byte((flaw == FLAW_NO_END) ? start_now : end_now);
        prev_snd = snd;
        prev_id = id;
    endtask

    task automatic send_random_frame();
        frame_flaw_t flaw;
        int          r, len;
        logic [7:0]  snd, tgt, id, junk;
        bit          dup;
        r = $urandom_range(0, 99);
        flaw = (r < 70) ? FLAW_NONE : (r < 78) ? FLAW_SUM : (r < 85) ? FLAW_NO_END :
               (r < 94) ? FLAW_CUT : FLAW_OVERSIZE;
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, MAX_PAYLOAD)
                                          : $urandom_range(0, 8);
        if (flaw == FLAW_OVERSIZE) len = $urandom_range(MAX_PAYLOAD + 1, 255);
        snd = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 3)) : 8'($urandom);
        r = $urandom_range(0, 99);
        tgt = (r < 45) ? own_addr_now : (r < 80) ? BROADCAST_ADDR : 8'($urandom);
        id = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 3)) : 8'($urandom);
        dup = ($urandom_range(0, 3) == 0);
        if (dup && $urandom_range(0, 1) == 1) begin
            snd = prev_snd;
            id = prev_id;
        end
        // line noise between frames is ignored by a hunting parser
        if ($urandom_range(0, 4) == 0) begin
            repeat ($urandom_range(1, 3)) begin
                do junk = 8'($urandom); while (is_flag(junk));
                send_byte(junk);
                link_bytes--;
            end
        end
        send_frame(dup, len, snd, tgt, id, flaw);
    endtask

    task automatic wait_idle();
        stop_source();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        while (words_pending != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // two end flags and an oversized non-flag byte leave the parser hunting
    // under any flag setting
    task automatic flush_parser();
        logic [7:0] filler;
        do filler = 8'($urandom_range(MAX_PAYLOAD + 1, 255)); while (is_flag(filler));
        send_byte(end_now);
        send_byte(end_now);
        send_byte(filler);
        wait_idle();
    endtask

    // all five registers plus one write to an unused index, valid held high
    task automatic program_regs(input logic [7:0] own, input logic [7:0] st,
                                input logic [7:0] dp, input logic [7:0] en,
                                input logic [7:0] es);
        logic [CFG_IDX_W-1:0] idx [6];
        logic [7:0]           val [6];
        idx = '{CFG_OWN_ADDR, CFG_START, CFG_DUP_START, CFG_END, CFG_ESCAPE,
                CFG_UNMAPPED + CFG_IDX_W'($urandom_range(0, 2))};
        val = '{own, st, dp, en, es, 8'($urandom)};
        cfg_valid <= 1'b1;
        for (int i = 0; i < 6; i++) begin
            cfg_index <= idx[i];
            cfg_data <= val[i];
            @(posedge aclk);
            while (!cfg_ready) @(posedge aclk);
        end
        cfg_valid <= 1'b0;
        own_addr_now = (own == BROADCAST_ADDR) ? 8'h00 : own;
        start_now = st;
        dup_now = dp;
        end_now = en;
        esc_now = es;
        stuffing_ok = !(st == dp || st == en || st == es || dp == en || dp == es || en == es);
    endtask

    initial begin
        logic [7:0] fa, fb, fc, fd;
        int         bytes_mark, words_mark;

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset settings: own address 0, default flags
        send_frame(0, 0, 8'h00, 8'h00, 8'h00, FLAW_NONE);             // empty frame
        send_frame(0, MAX_PAYLOAD, 8'hFF, BROADCAST_ADDR, 8'hFF, FLAW_NONE);
        // duplicate copy with the same id is dropped, with a new id it is kept
        send_frame(1, 0, 8'hFF, 8'h00, 8'hFF, FLAW_NONE);
        send_frame(1, 1, 8'hFF, 8'h00, 8'h7E, FLAW_NONE);
        send_frame(0, 255, 8'h01, 8'h00, 8'h02, FLAW_OVERSIZE);
        send_frame(0, 1, 8'h02, 8'h00, 8'h03, FLAW_SUM);
        send_frame(0, 0, 8'h03, 8'h00, 8'h04, FLAW_NO_END);
        send_frame(1, 2, 8'h05, BROADCAST_ADDR, 8'h06, FLAW_CUT);
        send_frame(0, 0, 8'h22, 8'h33, 8'h07, FLAW_NONE);             // someone else's
        // escape means nothing while hunting, the start after it still opens
        send_byte(esc_now);
        send_frame(0, 1, 8'h80, 8'h00, 8'h08, FLAW_NONE);
        flush_parser();

        // reserved own address is stored as 0; all four flags the same value
        program_regs(BROADCAST_ADDR, 8'hA5, 8'hA5, 8'hA5, 8'hA5);
        send_frame(0, 2, 8'h05, 8'h00, 8'h09, FLAW_NONE);
        flush_parser();

        // start equal to dup-start, end equal to escape
        program_regs(8'h10, 8'h40, 8'h40, 8'h41, 8'h41);
        send_frame(1, 1, 8'h08, BROADCAST_ADDR, 8'h0D, FLAW_NONE);
        flush_parser();

        // flag values at the ends of the byte range, own address at its top
        program_regs(8'hFE, 8'h00, 8'hFF, 8'h01, 8'hFE);
        send_frame(0, 0, 8'hFF, 8'hFE, 8'h00, FLAW_NONE);
        flush_parser();

        // random frames under random distinct flags
        do begin
            fa = 8'($urandom);
            fb = 8'($urandom);
            fc = 8'($urandom);
            fd = 8'($urandom);
        end while (fa == fb || fa == fc || fa == fd || fb == fc || fb == fd || fc == fd);
        program_regs(8'($urandom_range(0, 255)), fa, fb, fc, fd);
        bytes_mark = link_bytes;
        words_mark = words_predicted;
        while (link_bytes - bytes_mark < 20 || words_predicted - words_mark < 4)
            send_random_frame();
        flush_parser();

        wait_idle();
        if (fail_count == 0 && words_pending == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ----- serial_frame_receiver_top.f -----
hdl/sfr_pkg.sv
hdl/sfr_front.sv
hdl/sfr_frame_buf.sv
hdl/sfr_back.sv
hdl/serial_frame_receiver_top.sv
tb/serial_frame_receiver_checker.sv
tb/serial_frame_receiver_top_test.sv
